/* rtl/core/swdl_pkg.sv */
package swdl_pkg;

  // Default geometry
  localparam int NUM_TAPS_DEF   = 64;
  localparam int CENTRE_TAP_DEF = 51;

  // Field widths
  localparam int SAMP_W  = 16;
  localparam int TAP_W   = 24;
  localparam int STEP_W  = 24;
  localparam int SLOPE_W = 16;
  localparam int LEAK_W  = 24;
  localparam int CONF_W  = 13;
  localparam int LVL_W   = 4;
  localparam int ERR_W   = 17;
  localparam int SCALE_W = 37;
  localparam int OPB_W   = LEAK_W + 2;
  localparam int PROD_W  = SCALE_W + OPB_W;
  localparam int CFG_IDX_W = 2;

  // Unit tap in Q7.16
  localparam logic signed [TAP_W-1:0] TAP_ONE = 24'sd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAK  = 2'd2;

  typedef enum logic [1:0] {
    MODE_FIR,
    MODE_UPD,
    MODE_LEAK,
    MODE_ENERGY
  } pass_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIR,
    ST_SLICE,
    ST_CONF,
    ST_MULA,
    ST_MULB,
    ST_MULC,
    ST_UPD,
    ST_LEAK,
    ST_ENERGY,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic rotate;
    logic shift;
    logic unit;
  } cell_ctrl_t;

endpackage

/* rtl/core/swdl_cell.sv */
module swdl_cell import swdl_pkg::*; #(
  parameter logic signed [TAP_W-1:0] ResetTap = '0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [TAP_W-1:0]  tap_nb_i,
  input  logic signed [SAMP_W-1:0] samp_nb_i,
  output logic signed [TAP_W-1:0]  tap_o,
  output logic signed [SAMP_W-1:0] samp_o
);

  logic signed [TAP_W-1:0]  tap_q;
  logic signed [SAMP_W-1:0] samp_q;

  // Rotate the pair, shift the sample alone, or return the tap to its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= ResetTap;
      samp_q <= '0;
    end else if (ctrl_i.rotate) begin
      tap_q  <= tap_nb_i;
      samp_q <= samp_nb_i;
    end else if (ctrl_i.shift) begin
      samp_q <= samp_nb_i;
    end else if (ctrl_i.unit) begin
      tap_q  <= ResetTap;
    end
  end

  assign tap_o  = tap_q;
  assign samp_o = samp_q;

endmodule

/* rtl/core/swdl_head.sv */
module swdl_head import swdl_pkg::*; #(
  parameter int NumTaps = NUM_TAPS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pass_mode_e                mode_i,
  input  logic                      step_i,
  input  logic                      vld_i,
  input  logic                      clr_i,
  input  logic signed [TAP_W-1:0]   tap_i,
  input  logic signed [SAMP_W-1:0]  samp_i,
  input  logic signed [SCALE_W-1:0] scale_i,
  input  logic [LEAK_W:0]           keep_i,
  output logic signed [TAP_W-1:0]   tap_o,
  output logic signed [SAMP_W-1:0]  samp_o,
  output logic signed [TAP_W+SAMP_W+$clog2(NumTaps)-1:0] acc_o,
  output logic [2*TAP_W+$clog2(NumTaps)-1:0]             energy_o
);

  localparam int FirPW = TAP_W + SAMP_W;
  localparam int AccW  = FirPW + $clog2(NumTaps);
  localparam int EnW   = 2*TAP_W + $clog2(NumTaps);
  localparam int RndW  = PROD_W - 24;
  localparam int SumW  = RndW + 2;
  localparam logic signed [SumW-1:0] SatHi = SumW'(2**(TAP_W-1) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SumW'(2**(TAP_W-1));

  logic signed [SCALE_W-1:0] opa;
  logic signed [OPB_W-1:0]   opb;
  logic signed [PROD_W-1:0]  prod_d, s1_prod_q;
  logic signed [TAP_W-1:0]   s1_tap_q, s2_tap_q, s2_tap_d;
  logic signed [SAMP_W-1:0]  s1_samp_q, s2_samp_q;
  logic                      s1_vld_q;
  logic signed [AccW-1:0]    acc_q;
  logic [EnW-1:0]            energy_q;
  logic                      prod_neg;
  logic [PROD_W-1:0]         prod_mag;
  logic [RndW-1:0]           rnd;
  logic signed [SumW-1:0]    rnd_s, upd_sum;
  logic signed [SumW-1:0]    leak_val;

  // Pick multiplier operands for the running pass
  always_comb begin
    case (mode_i)
      MODE_UPD: opa = scale_i;
      default:  opa = SCALE_W'(tap_i);
    endcase
    case (mode_i)
      MODE_LEAK:   opb = OPB_W'($signed({1'b0, keep_i}));
      MODE_ENERGY: opb = OPB_W'(tap_i);
      default:     opb = OPB_W'(samp_i);
    endcase
  end

  assign prod_d = PROD_W'(opa * opb);

  // Product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (step_i) begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      s1_tap_q  <= tap_i;
      s1_samp_q <= samp_i;
      s1_prod_q <= prod_d;
    end
  end

  // Round the product half away from zero at bit 24
  assign prod_neg = s1_prod_q[PROD_W-1];
  assign prod_mag = prod_neg ? PROD_W'(-s1_prod_q) : PROD_W'(s1_prod_q);
  assign rnd      = RndW'((prod_mag + (PROD_W'(1) << 23)) >> 24);
  assign rnd_s    = SumW'($signed({1'b0, rnd}));
  assign upd_sum  = SumW'(s1_tap_q) + (prod_neg ? rnd_s : -rnd_s);
  assign leak_val = prod_neg ? -rnd_s : rnd_s;

  // Work out the tap that goes back into the ring
  always_comb begin
    case (mode_i)
      MODE_UPD: begin
        if (upd_sum > SatHi) s2_tap_d = TAP_W'(SatHi);
        else if (upd_sum < SatLo) s2_tap_d = TAP_W'(SatLo);
        else s2_tap_d = TAP_W'(upd_sum);
      end
      MODE_LEAK: s2_tap_d = TAP_W'(leak_val);
      default:   s2_tap_d = s1_tap_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      s2_tap_q  <= s2_tap_d;
      s2_samp_q <= s1_samp_q;
    end
  end

  // Accumulate filter sum and tap energy over real elements only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      energy_q <= '0;
    end else if (clr_i) begin
      acc_q    <= '0;
      energy_q <= '0;
    end else if (step_i && s1_vld_q) begin
      if (mode_i == MODE_FIR) begin
        acc_q <= acc_q + AccW'($signed(s1_prod_q[FirPW-1:0]));
      end
      if (mode_i == MODE_ENERGY) begin
        energy_q <= energy_q + EnW'(s1_prod_q[2*TAP_W-1:0]);
      end
    end
  end

  assign tap_o    = s2_tap_q;
  assign samp_o   = s2_samp_q;
  assign acc_o    = acc_q;
  assign energy_o = energy_q;

endmodule

/* rtl/core/soft_weighted_dd_lms_equalizer_top.sv */
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  sample, last_in_segment
// out       source     out_valid/out_stall equalized, decision, confidence, taps_reset
// cfg       sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each item runs: accept, filter pass, five slice and scale states (SLICE, CONF, MULA,
// MULB, MULC), update pass and a done state, plus leak pass, energy pass and check on
// the last sample of a segment. No new item is accepted until the state is back in idle.
// Each pass rotates the cell ring once through the two-stage multiply head; zero step or
// zero confidence drops the update pass, and zero leak drops the leak pass.
// Reset loads unit taps and zero samples at once; no clearing pass.
// A finished result waits in the output register while the next item is taken.
module soft_weighted_dd_lms_equalizer_top import swdl_pkg::*; #(
  parameter int NumTaps   = NUM_TAPS_DEF,
  parameter int CentreTap = CENTRE_TAP_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [SAMP_W-1:0]    sample_i,
  input  logic                        last_in_segment_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [SAMP_W-1:0]    equalized_o,
  output logic signed [LVL_W-1:0]     decision_o,
  output logic [CONF_W-1:0]           confidence_o,
  output logic                        taps_reset_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [STEP_W-1:0]           cfg_data_i
);

  localparam int CntW      = $clog2(NumTaps + 2);
  localparam int CentreIdx = CentreTap % NumTaps;
  localparam int AccW      = TAP_W + SAMP_W + $clog2(NumTaps);
  localparam int EnW       = 2*TAP_W + $clog2(NumTaps);
  localparam int RW        = AccW - 16;
  localparam logic [EnW-1:0] EnergyLimit = EnW'(2500) << 32;

  state_e state_q, state_d;
  cell_ctrl_t cell_ctrl;
  pass_mode_e mode;
  logic [CntW-1:0] cnt_q;
  logic pass_active, cnt_last, in_accept, out_load, over_limit;

  logic [STEP_W-1:0]  step_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [LEAK_W-1:0]  leak_q;
  logic last_q, flag_q, out_vld_q;

  logic signed [TAP_W-1:0]  tap_w  [NumTaps];
  logic signed [SAMP_W-1:0] samp_w [NumTaps];
  logic signed [TAP_W-1:0]  head_tap;
  logic signed [SAMP_W-1:0] head_samp, tail_samp;
  logic signed [AccW-1:0]   acc;
  logic [EnW-1:0]           energy;

  logic signed [SAMP_W-1:0] y_q, y_d;
  logic signed [LVL_W-1:0]  lvl_q, lvl_d;
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic [31:0]              p_q;
  logic [CONF_W-1:0]        conf_q, conf_d;
  logic [STEP_W+CONF_W-1:0] sc_q;
  logic signed [SCALE_W-1:0] scale_q, scale_d;
  logic [LEAK_W:0]          keep;

  logic signed [SAMP_W-1:0] out_y_q;
  logic signed [LVL_W-1:0]  out_lvl_q;
  logic [CONF_W-1:0]        out_conf_q;
  logic                     out_flag_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_W'(16777);
      slope_q <= SLOPE_W'(4096);
      leak_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STEP:  step_q  <= cfg_data_i;
        CFG_SLOPE: slope_q <= cfg_data_i[SLOPE_W-1:0];
        CFG_LEAK:  leak_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  assign keep = (LEAK_W+1)'(1 << LEAK_W) - {1'b0, leak_q};

  // Cell ring
  assign tail_samp = in_accept ? sample_i : head_samp;

  for (genvar k = 0; k < NumTaps; k++) begin : g_cell
    localparam logic signed [TAP_W-1:0] RstTap = (k == CentreIdx) ? TAP_ONE : '0;
    if (k == NumTaps - 1) begin : g_tail
      swdl_cell #(.ResetTap(RstTap)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (cell_ctrl),
        .tap_nb_i  (head_tap),
        .samp_nb_i (tail_samp),
        .tap_o     (tap_w[k]),
        .samp_o    (samp_w[k])
      );
    end else begin : g_body
      swdl_cell #(.ResetTap(RstTap)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (cell_ctrl),
        .tap_nb_i  (tap_w[k+1]),
        .samp_nb_i (samp_w[k+1]),
        .tap_o     (tap_w[k]),
        .samp_o    (samp_w[k])
      );
    end
  end

  swdl_head #(.NumTaps(NumTaps)) u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mode_i   (mode),
    .step_i   (pass_active),
    .vld_i    (cnt_q < CntW'(NumTaps)),
    .clr_i    (state_q == ST_IDLE),
    .tap_i    (tap_w[0]),
    .samp_i   (samp_w[0]),
    .scale_i  (scale_q),
    .keep_i   (keep),
    .tap_o    (head_tap),
    .samp_o   (head_samp),
    .acc_o    (acc),
    .energy_o (energy)
  );

  // Pass counter
  assign pass_active = (state_q == ST_FIR) || (state_q == ST_UPD) ||
                       (state_q == ST_LEAK) || (state_q == ST_ENERGY);
  assign cnt_last    = (cnt_q == CntW'(NumTaps + 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (pass_active && !cnt_last) begin
      cnt_q <= cnt_q + 1'b1;
    end else begin
      cnt_q <= '0;
    end
  end

  assign in_accept  = in_valid_i && !in_stall_o;
  assign over_limit = energy > EnergyLimit;
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_FIR;
      ST_FIR:   if (cnt_last) state_d = ST_SLICE;
      ST_SLICE: state_d = ST_CONF;
      ST_CONF:  state_d = ST_MULA;
      ST_MULA:  state_d = ST_MULB;
      ST_MULB:  state_d = ST_MULC;
      ST_MULC: begin
        if (step_q != '0 && conf_q != '0) state_d = ST_UPD;
        else if (!last_q) state_d = ST_DONE;
        else if (leak_q != '0) state_d = ST_LEAK;
        else state_d = ST_ENERGY;
      end
      ST_UPD: begin
        if (cnt_last) begin
          if (!last_q) state_d = ST_DONE;
          else if (leak_q != '0) state_d = ST_LEAK;
          else state_d = ST_ENERGY;
        end
      end
      ST_LEAK:   if (cnt_last) state_d = ST_ENERGY;
      ST_ENERGY: if (cnt_last) state_d = ST_CHECK;
      ST_CHECK:  state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o       = (state_q != ST_IDLE);
    cell_ctrl.rotate = pass_active;
    cell_ctrl.shift  = (state_q == ST_IDLE) && in_valid_i;
    cell_ctrl.unit   = (state_q == ST_CHECK) && over_limit;
    case (state_q)
      ST_UPD:    mode = MODE_UPD;
      ST_LEAK:   mode = MODE_LEAK;
      ST_ENERGY: mode = MODE_ENERGY;
      default:   mode = MODE_FIR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        last_q <= last_in_segment_i;
        flag_q <= 1'b0;
      end else if (state_q == ST_CHECK) begin
        flag_q <= over_limit;
      end
    end
  end

  // Round and saturate the filter sum to Q5.10
  always_comb begin
    logic            neg;
    logic [AccW-1:0] mag;
    logic [RW-1:0]   r;
    neg = acc[AccW-1];
    mag = neg ? AccW'(-acc) : AccW'(acc);
    r   = RW'((mag + AccW'(1 << 15)) >> 16);
    if (!neg) y_d = (r > RW'(32767)) ? 16'sh7fff : SAMP_W'(r);
    else      y_d = (r > RW'(32768)) ? 16'sh8000 : SAMP_W'(-r);
  end

  // Slice to the nearest odd level and form the error
  always_comb begin
    logic [SAMP_W:0] a;
    logic [1:0]      n;
    logic [2:0]      m;
    a     = y_q[SAMP_W-1] ? (SAMP_W+1)'(-y_q) : (SAMP_W+1)'(y_q);
    n     = (a[SAMP_W:11] > 6'd3) ? 2'd3 : a[12:11];
    m     = {n, 1'b1};
    lvl_d = y_q[SAMP_W-1] ? -LVL_W'({1'b0, m}) : LVL_W'({1'b0, m});
    err_d = ERR_W'(y_q) - (ERR_W'(lvl_d) <<< 10);
  end

  // Confidence from the rounded error product
  always_comb begin
    logic [22:0] q;
    q      = 23'((p_q + 32'd512) >> 10);
    conf_d = (q >= 23'd4096) ? '0 : CONF_W'(23'd4096 - q);
  end

  // Step scale, rounded half away from zero at bit 16
  always_comb begin
    logic [ERR_W-2:0]               em;
    logic [STEP_W+CONF_W+ERR_W-2:0] m;
    logic [SCALE_W-1:0]             r;
    em      = err_q[ERR_W-1] ? (ERR_W-1)'(-err_q) : (ERR_W-1)'(err_q);
    m       = sc_q * em;
    r       = SCALE_W'((m + (STEP_W+CONF_W+ERR_W-1)'(1 << 15)) >> 16);
    scale_d = err_q[ERR_W-1] ? -$signed(r) : $signed(r);
  end

  // Per-item arithmetic registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SLICE: y_q <= y_d;
      ST_CONF: begin
        lvl_q <= lvl_d;
        err_q <= err_d;
        p_q   <= 32'(err_d[ERR_W-1] ? (ERR_W-1)'(-err_d) : (ERR_W-1)'(err_d)) * 32'(slope_q);
      end
      ST_MULA:  conf_q  <= conf_d;
      ST_MULB:  sc_q    <= step_q * conf_q;
      ST_MULC:  scale_q <= scale_d;
      default:  ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_y_q    <= y_q;
      out_lvl_q  <= lvl_q;
      out_conf_q <= conf_q;
      out_flag_q <= flag_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign equalized_o  = out_y_q;
  assign decision_o   = out_lvl_q;
  assign confidence_o = out_conf_q;
  assign taps_reset_o = out_flag_q;

endmodule

/* rtl/core/swdl_checker.sv */
module swdl_checker import swdl_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [SAMP_W-1:0] equalized_o,
  input logic signed [LVL_W-1:0]  decision_o,
  input logic [CONF_W-1:0]        confidence_o,
  input logic                     taps_reset_o
);

  // One transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item still in work");

  // Held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(equalized_o) &&
      $stable(decision_o) && $stable(confidence_o) && $stable(taps_reset_o))
    else $error("stalled result changed");

  // Decision is an odd level
  a_odd_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decision_o[0])
    else $error("decision not an odd level");

  // Confidence never above one
  a_conf_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> confidence_o <= 13'd4096)
    else $error("confidence above 1.0");

endmodule

bind soft_weighted_dd_lms_equalizer_top swdl_checker u_swdl_checker (.*);

/* bench/tb_soft_weighted_dd_lms_equalizer_top.sv */
module tb_soft_weighted_dd_lms_equalizer_top;
  import swdl_pkg::*;

  localparam int TAPS = NUM_TAPS_DEF;
  localparam int CENTRE = CENTRE_TAP_DEF % NUM_TAPS_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4 * NUM_TAPS_DEF + 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [SAMP_W-1:0] sample;
    logic                     last;
  } symbol_t;

  typedef struct {
    logic signed [SAMP_W-1:0] equalized;
    logic signed [LVL_W-1:0]  decision;
    logic [CONF_W-1:0]        confidence;
    logic                     taps_reset;
  } slicer_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMP_W-1:0] sample_i = '0;
  logic last_in_segment_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMP_W-1:0] equalized_o;
  logic signed [LVL_W-1:0] decision_o;
  logic [CONF_W-1:0] confidence_o;
  logic taps_reset_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [STEP_W-1:0] cfg_data_i = '0;

  soft_weighted_dd_lms_equalizer_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow equaliser state
  logic [STEP_W-1:0]         mdl_step;
  logic [SLOPE_W-1:0]        mdl_slope;
  logic [LEAK_W-1:0]         mdl_leak;
  logic signed [SAMP_W-1:0]  mdl_line [TAPS];
  logic signed [TAP_W-1:0]   mdl_taps [TAPS];

  symbol_t     pending_symbols[$];
  slicer_out_t expected_slices[$];
  bit  failed = 1'b0;
  bit  in_taken = 1'b0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;
  int  in_gap = 0;
  int  stall_left = 0;
  int  quiet_count = 0;

  function automatic longint round_away(longint v, int s);
    longint unsigned m;
    m = v < 0 ? longint'(-v) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic load_unit_taps();
    foreach (mdl_taps[k]) mdl_taps[k] = '0;
    mdl_taps[CENTRE] = TAP_ONE;
  endtask

  // Advance the shadow equaliser by one symbol and return its slicer output
  task automatic equalize_symbol(input symbol_t s, output slicer_out_t r);
    longint acc, y, lvl, err, scale, d, keep, n, a;
    longint unsigned aerr, q, energy;
    for (int k = TAPS - 1; k > 0; k--) mdl_line[k] = mdl_line[k-1];
    mdl_line[0] = s.sample;
    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += longint'(mdl_taps[k]) * mdl_line[TAPS-1-k];
    y = clip(round_away(acc, 16), -32768, 32767);
    a = y < 0 ? -y : y;
    n = a >> 11;
    if (n > 3) n = 3;
    lvl = y >= 0 ? 2 * n + 1 : -(2 * n + 1);
    err = y - lvl * 1024;
    aerr = err < 0 ? -err : err;
    q = (aerr * mdl_slope + 512) >> 10;
    r.confidence = q >= 4096 ? '0 : CONF_W'(4096 - q);
    r.taps_reset = 1'b0;
    if (mdl_step != 0 && r.confidence != 0) begin
      scale = round_away(longint'(mdl_step) * longint'(r.confidence) * err, 16);
      for (int k = 0; k < TAPS; k++) begin
        d = round_away(scale * mdl_line[TAPS-1-k], 24);
        mdl_taps[k] = TAP_W'(clip(longint'(mdl_taps[k]) - d, -8388608, 8388607));
      end
    end
    if (s.last) begin
      if (mdl_leak != 0) begin
        keep = 64'd16777216 - mdl_leak;
        foreach (mdl_taps[k]) mdl_taps[k] = TAP_W'(round_away(longint'(mdl_taps[k]) * keep, 24));
      end
      energy = 0;
      foreach (mdl_taps[k]) energy += longint'(mdl_taps[k]) * longint'(mdl_taps[k]);
      if (energy > (64'd2500 << 32)) begin
        load_unit_taps();
        r.taps_reset = 1'b1;
      end
    end
    r.equalized = SAMP_W'(y);
    r.decision = LVL_W'(lvl);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Check results and record accepted symbols
  always @(posedge clk_i) begin
    slicer_out_t exp_r, got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_slices.size() == 0) begin
          $error("result with no expectation: equalized %0d", equalized_o);
          failed = 1'b1;
        end else begin
          exp_r = expected_slices.pop_front();
          if (equalized_o !== exp_r.equalized) begin
            $error("equalized expected %0d actual %0d", exp_r.equalized, equalized_o);
            failed = 1'b1;
          end
          if (decision_o !== exp_r.decision) begin
            $error("decision expected %0d actual %0d", exp_r.decision, decision_o);
            failed = 1'b1;
          end
          if (confidence_o !== exp_r.confidence) begin
            $error("confidence expected %0d actual %0d", exp_r.confidence, confidence_o);
            failed = 1'b1;
          end
          if (taps_reset_o !== exp_r.taps_reset) begin
            $error("taps_reset expected %0d actual %0d", exp_r.taps_reset, taps_reset_o);
            failed = 1'b1;
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        equalize_symbol('{sample: sample_i, last: last_in_segment_i}, got);
        expected_slices.push_back(got);
      end
      // Watchdog on transactions of any channel
      if (in_taken || (out_valid_o && !out_stall_i) || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Feed symbols with random gaps; hold payload while stalled; stall the output at random
  always @(negedge clk_i) begin
    symbol_t s;
    if (++quiet_count >= 300) begin
      quiet_count = 0;
      quiet = ($urandom_range(0, 3) == 0);
    end
    if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_symbols.size() > 0) begin
        s = pending_symbols.pop_front();
        sample_i <= s.sample;
        last_in_segment_i <= s.last;
        in_valid_i <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = pick_gap();
    end
  end

  task automatic drain();
    while (pending_symbols.size() > 0 || in_valid_i || expected_slices.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_STEP:  mdl_step = data;
      CFG_SLOPE: mdl_slope = data[SLOPE_W-1:0];
      CFG_LEAK:  mdl_leak = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_symbol(int v, bit last);
    pending_symbols.push_back('{sample: SAMP_W'(v), last: last});
  endtask

  // Mostly clean 8-VSB segments, some full-range noise
  task automatic queue_random(int count);
    int made, seg, lvl;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) < 8) begin
        seg = $urandom_range(1, 24);
        for (int i = 0; i < seg; i++) begin
          lvl = 2 * $urandom_range(0, 7) - 7;
          push_symbol(lvl * 1024 + $urandom_range(0, 600) - 300, i == seg - 1);
        end
        made += seg;
      end else begin
        push_symbol($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        made++;
      end
    end
  endtask

  initial begin
    mdl_step = 24'd16777;
    mdl_slope = 16'd4096;
    mdl_leak = '0;
    foreach (mdl_line[k]) mdl_line[k] = '0;
    load_unit_taps();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes and exact levels under reset settings
    push_symbol(0, 0);
    push_symbol(32767, 0);
    push_symbol(-32768, 0);
    push_symbol(7 * 1024, 0);
    push_symbol(-7 * 1024, 0);
    push_symbol(1024, 0);
    push_symbol(-1024, 1);
    push_symbol(2048, 0);
    push_symbol(-3000, 1);
    drain();

    // Zero step: no adaptation
    write_reg(CFG_STEP, '0);
    write_reg(CFG_UNUSED, 24'hFFFFFF);
    push_symbol(5000, 0);
    push_symbol(-5000, 1);
    drain();

    // Maximum step, flat gate: drive taps to saturation and divergence reset
    write_reg(CFG_STEP, 24'hFFFFFF);
    write_reg(CFG_SLOPE, '0);
    for (int i = 0; i < 10; i++) push_symbol(i[0] ? 32767 : -32768, i % 3 == 2);
    drain();

    // Full leak with wide slope bits masked off
    write_reg(CFG_LEAK, 24'hFFFFFF);
    write_reg(CFG_SLOPE, 24'hABFFFF);
    push_symbol(3000, 1);
    push_symbol(-2500, 1);
    drain();

    // Random phases across settings
    write_reg(CFG_STEP, 24'd16777);
    write_reg(CFG_SLOPE, 24'd4096);
    write_reg(CFG_LEAK, '0);
    queue_random(200);
    drain();
    write_reg(CFG_STEP, 24'd200000);
    write_reg(CFG_SLOPE, 24'd1024);
    write_reg(CFG_LEAK, 24'd1000);
    queue_random(180);
    drain();
    write_reg(CFG_STEP, 24'hFFFFFF);
    write_reg(CFG_SLOPE, 24'h00FFFF);
    write_reg(CFG_LEAK, 24'd1);
    queue_random(150);
    drain();
    write_reg(CFG_STEP, STEP_W'($urandom_range(0, 24'hFFFFFF)));
    write_reg(CFG_SLOPE, STEP_W'($urandom_range(0, 16'hFFFF)));
    write_reg(CFG_LEAK, STEP_W'($urandom_range(0, 24'hFFFF)));
    queue_random(220);
    drain();

    if (!failed && expected_slices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/swdl_pkg.sv
rtl/core/swdl_cell.sv
rtl/core/swdl_head.sv
rtl/core/soft_weighted_dd_lms_equalizer_top.sv
rtl/core/swdl_checker.sv
bench/tb_soft_weighted_dd_lms_equalizer_top.sv
